@@ rtl/mpdc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpdc_pkg
// Shared types and constants of the metered pump dispense controller.
// ----------------------------------------------------------------------------
package mpdc_pkg;

  localparam int CMD_W    = 3;
  localparam int HALL_W   = 4;
  localparam int SAMPLE_W = 10;
  localparam int TICK_W   = 32;
  localparam int DRIVE_W  = 8;
  localparam int OC_W     = 8;
  localparam int THRESH_W = 10;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 10'd465;
  localparam logic [DRIVE_W-1:0]  FULL_DRIVE   = 8'd255;
  localparam logic [OC_W-1:0]     OC_MAX       = 8'd255;

  typedef enum logic [CMD_W-1:0] {
    CMD_HALL_SAMPLE    = 3'd0,
    CMD_CURRENT_SAMPLE = 3'd1,
    CMD_START          = 3'd2,
    CMD_SET_SPEED      = 3'd3,
    CMD_CLEAR_TICKS    = 3'd4,
    CMD_CLEAR_FAULT    = 3'd5
  } cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [HALL_W-1:0]   hall_levels;
    logic [SAMPLE_W-1:0] current_sample;
    logic [TICK_W-1:0]   tick_amount;
    logic [DRIVE_W-1:0]  speed;
  } item_t;

  typedef struct packed {
    logic [DRIVE_W-1:0] motor_drive;
    logic               is_running;
    logic               fault;
    logic [TICK_W-1:0]  tick_total;
    logic               done_pulse;
  } result_t;

endpackage

@@ rtl/mpdc_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpdc_in_if
// Request channel into the dispense controller: valid/ready and one command.
// ----------------------------------------------------------------------------
interface mpdc_in_if;
  import mpdc_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [HALL_W-1:0]   hall_levels;
  logic [SAMPLE_W-1:0] current_sample;
  logic [TICK_W-1:0]   tick_amount;
  logic [DRIVE_W-1:0]  speed;

  modport source (
    output valid, command, hall_levels, current_sample, tick_amount, speed,
    input  ready
  );

  modport sink (
    input  valid, command, hall_levels, current_sample, tick_amount, speed,
    output ready
  );
endinterface

@@ rtl/mpdc_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpdc_out_if
// Status channel out of the dispense controller: valid/ready and one report.
// ----------------------------------------------------------------------------
interface mpdc_out_if;
  import mpdc_pkg::*;

  logic               valid;
  logic               ready;
  logic [DRIVE_W-1:0] motor_drive;
  logic               is_running;
  logic               fault;
  logic [TICK_W-1:0]  tick_total;
  logic               done_pulse;

  modport source (
    output valid, motor_drive, is_running, fault, tick_total, done_pulse,
    input  ready
  );

  modport sink (
    input  valid, motor_drive, is_running, fault, tick_total, done_pulse,
    output ready
  );
endinterface

@@ rtl/mpdc_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpdc_core
// Controller state and the combinational update applied to each request.
// ----------------------------------------------------------------------------
module mpdc_core #(
  parameter int FAULT_SAMPLE_LIMIT = 3
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [mpdc_pkg::THRESH_W-1:0]      cfg_wdata,
  input  logic                               step,
  input  mpdc_pkg::item_t                    item,
  output mpdc_pkg::result_t                  result
);
  import mpdc_pkg::*;

  localparam logic [OC_W-1:0] LIMIT = OC_W'(FAULT_SAMPLE_LIMIT);

  logic [THRESH_W-1:0] thresh_r;
  logic [HALL_W-1:0]   hall_last_r, hall_last_nxt;
  logic [TICK_W-1:0]   tick_r, tick_nxt;
  logic [TICK_W-1:0]   target_r, target_nxt;
  logic                running_r, running_nxt;
  logic [OC_W-1:0]     oc_r, oc_nxt;
  logic                fault_r, fault_nxt;
  logic [DRIVE_W-1:0]  drive_r, drive_nxt;
  logic                done;

  logic [HALL_W-1:0] hall_diff;
  logic [2:0]        hall_changes;
  logic [TICK_W-1:0] tick_hall;
  logic [OC_W-1:0]   oc_bumped;

  assign hall_diff    = item.hall_levels ^ hall_last_r;
  assign hall_changes = 3'(hall_diff[0]) + 3'(hall_diff[1])
                      + 3'(hall_diff[2]) + 3'(hall_diff[3]);
  assign tick_hall    = tick_r + TICK_W'(hall_changes);
  assign oc_bumped    = (item.current_sample >= thresh_r && oc_r != OC_MAX)
                      ? oc_r + OC_W'(1) : oc_r;

  always_comb begin
    hall_last_nxt = hall_last_r;
    tick_nxt      = tick_r;
    target_nxt    = target_r;
    running_nxt   = running_r;
    oc_nxt        = oc_r;
    fault_nxt     = fault_r;
    drive_nxt     = drive_r;
    done          = 1'b0;
    unique case (item.command)
      CMD_HALL_SAMPLE: begin
        tick_nxt      = tick_hall;
        hall_last_nxt = item.hall_levels;
        if (target_r != '0 && tick_hall >= target_r) begin
          target_nxt  = '0;
          running_nxt = 1'b0;
          drive_nxt   = '0;
          done        = 1'b1;
        end
      end
      CMD_CURRENT_SAMPLE: begin
        if (running_r) begin
          oc_nxt = oc_bumped;
          // The limit is checked on every sample of a run, over threshold or not.
          if (oc_bumped >= LIMIT) begin
            target_nxt  = '0;
            running_nxt = 1'b0;
            drive_nxt   = '0;
            fault_nxt   = 1'b1;
          end
        end
      end
      CMD_START: begin
        if (!running_r && !fault_r) begin
          target_nxt  = tick_r + item.tick_amount;
          running_nxt = 1'b1;
          drive_nxt   = FULL_DRIVE;
        end
      end
      CMD_SET_SPEED: begin
        if (!fault_r) drive_nxt = item.speed;
      end
      CMD_CLEAR_TICKS: begin
        if (!running_r) tick_nxt = '0;
      end
      CMD_CLEAR_FAULT: begin
        fault_nxt = 1'b0;
        oc_nxt    = '0;
        drive_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r    <= THRESH_RESET;
      hall_last_r <= '0;
      tick_r      <= '0;
      target_r    <= '0;
      running_r   <= 1'b0;
      oc_r        <= '0;
      fault_r     <= 1'b0;
      drive_r     <= '0;
    end else begin
      if (cfg_we) thresh_r <= cfg_wdata;
      if (step) begin
        hall_last_r <= hall_last_nxt;
        tick_r      <= tick_nxt;
        target_r    <= target_nxt;
        running_r   <= running_nxt;
        oc_r        <= oc_nxt;
        fault_r     <= fault_nxt;
        drive_r     <= drive_nxt;
      end
    end
  end

  always_comb begin
    result.motor_drive = drive_nxt;
    result.is_running  = running_nxt;
    result.fault       = fault_nxt;
    result.tick_total  = tick_nxt;
    result.done_pulse  = done;
  end
endmodule

@@ rtl/metered_pump_dispense_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// metered_pump_dispense_controller
// Hall tick metering, dispense target and overcurrent fault for a pump.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one request per handshake: a hall sample, a current sample,
//   start dispense, set speed, clear ticks or clear fault. out_ch returns one
//   status report per request (drive level, running, fault, tick count and a
//   done flag), in request order.
//   cfg_we/cfg_wdata write the overcurrent threshold; write it while idle.
//   A request is registered on acceptance; once the output register is
//   free it is applied to the state and its report registered at that edge.
//   One request is taken every cycle while reports are taken; the update of
//   the state is a single pass of logic, so request n+1 sees all of request n.
//   When the receiver stalls, the report holds, the input register fills and
//   in_ch.ready drops until the report is taken.
//   Synchronous reset clears the controller state, sets the threshold to 465 and drops
//   both valid flags.
// ----------------------------------------------------------------------------
module metered_pump_dispense_controller #(
  parameter int FAULT_SAMPLE_LIMIT = 3
) (
  input  logic                          clk,
  input  logic                          rst_n,
  mpdc_in_if.sink                       in_ch,
  mpdc_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [mpdc_pkg::THRESH_W-1:0] cfg_wdata
);
  import mpdc_pkg::*;

  logic    in_v_r;
  item_t   in_item_r;
  logic    out_v_r;
  result_t out_res_r;
  result_t res;
  logic    out_free;
  logic    step;

  assign out_free    = !out_v_r || out_ch.ready;
  assign step        = in_v_r && out_free;
  assign in_ch.ready = !in_v_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ch.ready) in_v_r <= in_ch.valid;
      if (out_free) out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_item_r.command        <= in_ch.command;
      in_item_r.hall_levels    <= in_ch.hall_levels;
      in_item_r.current_sample <= in_ch.current_sample;
      in_item_r.tick_amount    <= in_ch.tick_amount;
      in_item_r.speed          <= in_ch.speed;
    end
    if (step) out_res_r <= res;
  end

  mpdc_core #(
    .FAULT_SAMPLE_LIMIT(FAULT_SAMPLE_LIMIT)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .item      (in_item_r),
    .result    (res)
  );

  assign out_ch.valid       = out_v_r;
  assign out_ch.motor_drive = out_res_r.motor_drive;
  assign out_ch.is_running  = out_res_r.is_running;
  assign out_ch.fault       = out_res_r.fault;
  assign out_ch.tick_total  = out_res_r.tick_total;
  assign out_ch.done_pulse  = out_res_r.done_pulse;
endmodule

@@ rtl/mpdc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpdc_checker
// Port-level checks of the dispense controller, bound to the top level.
// ----------------------------------------------------------------------------
module mpdc_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [mpdc_pkg::DRIVE_W-1:0] out_motor_drive,
  input logic                         out_is_running,
  input logic                         out_fault,
  input logic [mpdc_pkg::TICK_W-1:0]  out_tick_total,
  input logic                         out_done_pulse
);
  import mpdc_pkg::*;

  // A stalled report must not change under the receiver.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_tick_total)
      && $stable(out_motor_drive) && $stable(out_done_pulse))
    else $error("stalled report changed");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("report valid right after reset");

  // Reaching the target stops the motor and ends the run.
  a_done_stops: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_pulse |-> !out_is_running && out_motor_drive == '0)
    else $error("done reported with motor still running");

  // A run can neither continue past a fault nor start while one is latched.
  a_fault_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fault |-> !out_is_running && !out_done_pulse)
    else $error("running while fault latched");
endmodule

bind metered_pump_dispense_controller mpdc_checker u_mpdc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_motor_drive (out_ch.motor_drive),
  .out_is_running  (out_ch.is_running),
  .out_fault       (out_ch.fault),
  .out_tick_total  (out_ch.tick_total),
  .out_done_pulse  (out_ch.done_pulse)
);
